/* rtl/tlbpt_pkg.sv */
// Shared constants and command type for the TLB page-table translator.
// No dependencies; imported by every module of the block.
`default_nettype none

package tlbpt_pkg;

	// Address layout: page number above offset.
	localparam int ADDR_W          = 16;
	localparam int PAGE_COUNT      = 256;
	localparam int PAGE_BYTES      = 256;
	localparam int PAGE_W          = $clog2(PAGE_COUNT);
	localparam int OFFSET_W        = $clog2(PAGE_BYTES);
	localparam int FRAME_OUT_W     = 8;
	localparam int CNT_W           = 32;

	// Defaults for the top-level parameters.
	localparam int TLB_ENTRIES_DEF = 16;
	localparam int FRAME_COUNT_DEF = 256;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;    // capture the address, start the page-table read
		logic commit;  // resolve the frame, update state, load the result
	} cmd_t;

endpackage

`default_nettype wire

/* rtl/tlbpt_ctrl.sv */
// Controller for the translator: handshake and two-state sequencer.
// Depends on tlbpt_pkg for the command type.
`default_nettype none

module tlbpt_ctrl
	import tlbpt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output cmd_t      cmd
);

	localparam logic ST_IDLE    = 1'b0;
	localparam logic ST_RESOLVE = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign cmd.load   = in_valid && (state_q == ST_IDLE);
	assign cmd.commit = (state_q == ST_RESOLVE) && out_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/tlbpt_tlb.sv */
// LRU-ordered TLB: parallel tag compare and shift-down update.
// Depends on tlbpt_pkg for the page width.
`default_nettype none

module tlbpt_tlb
	import tlbpt_pkg::*;
#(
	parameter int ENTRIES = TLB_ENTRIES_DEF,
	parameter int FW      = $clog2(FRAME_COUNT_DEF)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [PAGE_W-1:0] page,
	input  wire logic              update,
	input  wire logic [FW-1:0]     ins_frame,
	output logic                   hit,
	output logic [FW-1:0]          hit_frame
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	logic [PAGE_W-1:0] tag_q   [ENTRIES];
	logic [FW-1:0]     frame_q [ENTRIES];
	logic [CW-1:0]     fill_q;

	logic [ENTRIES-1:0] match;
	logic [IW-1:0]      hit_pos;
	logic               full;
	logic [CW-1:0]      fill_m1;
	logic [IW-1:0]      last_idx;
	logic [IW-1:0]      first_idx;

	// Tags are unique among filled entries, so an OR over the match lanes
	// yields the single matching position and frame.
	always_comb begin
		hit_pos   = '0;
		hit_frame = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = (CW'(i) < fill_q) && (tag_q[i] == page);
			if (match[i]) begin
				hit_pos   = hit_pos | IW'(i);
				hit_frame = hit_frame | frame_q[i];
			end
		end
		hit = |match;
	end

	assign full    = (fill_q == CW'(ENTRIES));
	assign fill_m1 = fill_q - CW'(1);

	// Hit: shift hit..fill-1 down. Miss, not full: append at fill.
	// Miss, full: drop entry 0 and shift everything down.
	always_comb begin
		if (hit) begin
			last_idx  = fill_m1[IW-1:0];
			first_idx = hit_pos;
		end else if (full) begin
			last_idx  = IW'(ENTRIES - 1);
			first_idx = '0;
		end else begin
			last_idx  = fill_q[IW-1:0];
			first_idx = fill_q[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			for (int k = 0; k < ENTRIES; k++) begin
				if (IW'(k) == last_idx) begin
					tag_q[k]   <= page;
					frame_q[k] <= ins_frame;
				end else if (k < ENTRIES - 1 && IW'(k) >= first_idx && IW'(k) < last_idx) begin
					tag_q[k]   <= tag_q[(k + 1) % ENTRIES];
					frame_q[k] <= frame_q[(k + 1) % ENTRIES];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (update && !hit && !full) begin
			fill_q <= fill_q + CW'(1);
		end
	end

endmodule

`default_nettype wire

/* rtl/tlbpt_datapath.sv */
// Datapath: address capture, page table memory and valid bits, frame
// allocation, counters and result registers. Uses tlbpt_tlb and tlbpt_pkg.
`default_nettype none

module tlbpt_datapath
	import tlbpt_pkg::*;
#(
	parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
	parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd,
	input  wire logic [ADDR_W-1:0]      logical_address,
	output logic [ADDR_W-1:0]           physical_address,
	output logic [FRAME_OUT_W-1:0]      frame_number,
	output logic                        tlb_hit,
	output logic                        page_fault,
	output logic [CNT_W-1:0]            hit_total,
	output logic [CNT_W-1:0]            fault_total
);

	localparam int FW     = $clog2(FRAME_COUNT);
	localparam int PHYS_W = FW + OFFSET_W;

	logic [PAGE_W-1:0]   page_in;
	logic [PAGE_W-1:0]   page_q;
	logic [OFFSET_W-1:0] offset_q;

	logic [FW-1:0]         pt_mem [PAGE_COUNT];
	logic [FW-1:0]         pt_rd_q;
	logic [PAGE_COUNT-1:0] pvalid_q;
	logic                  pv_rd_q;

	logic [FW-1:0]    next_free_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] fault_cnt_q;

	logic              hit;
	logic [FW-1:0]     hit_frame;
	logic              fault;
	logic [FW-1:0]     frame;
	logic [PHYS_W-1:0] phys_wide;

	logic [ADDR_W-1:0]      phys_q;
	logic [FRAME_OUT_W-1:0] frame_out_q;
	logic                   hit_out_q;
	logic                   fault_out_q;

	assign page_in = logical_address[OFFSET_W +: PAGE_W];

	tlbpt_tlb #(
		.ENTRIES (TLB_ENTRIES),
		.FW      (FW)
	) u_tlb (
		.clk       (clk),
		.arst_n    (arst_n),
		.page      (page_q),
		.update    (cmd.commit),
		.ins_frame (frame),
		.hit       (hit),
		.hit_frame (hit_frame)
	);

	assign fault     = !hit && !pv_rd_q;
	assign frame     = hit ? hit_frame : (pv_rd_q ? pt_rd_q : next_free_q);
	assign phys_wide = {frame, offset_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q   <= page_in;
			offset_q <= logical_address[OFFSET_W-1:0];
			pt_rd_q  <= pt_mem[page_in];
			pv_rd_q  <= pvalid_q[page_in];
		end
		if (cmd.commit && fault) begin
			pt_mem[page_q] <= next_free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q    <= '0;
			next_free_q <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else if (cmd.commit) begin
			if (hit && hit_cnt_q != '1) begin
				hit_cnt_q <= hit_cnt_q + CNT_W'(1);
			end
			if (fault) begin
				pvalid_q[page_q] <= 1'b1;
				next_free_q <= (next_free_q == FW'(FRAME_COUNT - 1)) ? '0
				                                                     : next_free_q + FW'(1);
				if (fault_cnt_q != '1) begin
					fault_cnt_q <= fault_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			phys_q      <= ADDR_W'(phys_wide);
			frame_out_q <= FRAME_OUT_W'(frame);
			hit_out_q   <= hit;
			fault_out_q <= fault;
		end
	end

	assign physical_address = phys_q;
	assign frame_number     = frame_out_q;
	assign tlb_hit          = hit_out_q;
	assign page_fault       = fault_out_q;
	// counters change only at commit, so they match the held result
	assign hit_total        = hit_cnt_q;
	assign fault_total      = fault_cnt_q;

endmodule

`default_nettype wire

/* rtl/tlb_page_table_translator_unit.sv */
// A transaction is accepted only in idle; acceptance captures the address and reads the
// page-table memory. Commit then resolves the frame, updates TLB and table and loads the
// result register; it waits while an earlier result still waits in the output register.
// No new transaction is accepted until the current one has committed.
// Reset (arst_n low): sequencer idle, no result pending, TLB empty, all pages
// unmapped, next free frame and both counters zero; page table not cleared.
`default_nettype none

module tlb_page_table_translator_unit
	import tlbpt_pkg::*;
#(
	parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
	parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input transaction
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [ADDR_W-1:0]      logical_address,
	// result transaction
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [ADDR_W-1:0]           physical_address,
	output logic [FRAME_OUT_W-1:0]      frame_number,
	output logic                        tlb_hit,
	output logic                        page_fault,
	output logic [CNT_W-1:0]            hit_total,
	output logic [CNT_W-1:0]            fault_total
);

	cmd_t cmd;

	// Sequencer: accept in idle, then commit once the result register is free.
	tlbpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath: TLB lookup, page-table walk, frame allocation, result hold.
	tlbpt_datapath #(
		.TLB_ENTRIES (TLB_ENTRIES),
		.FRAME_COUNT (FRAME_COUNT)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.logical_address  (logical_address),
		.physical_address (physical_address),
		.frame_number     (frame_number),
		.tlb_hit          (tlb_hit),
		.page_fault       (page_fault),
		.hit_total        (hit_total),
		.fault_total      (fault_total)
	);

endmodule

`default_nettype wire
